// ----- src/simtwo_pkg.sv -----
// ----------------------------------------------------------------------------
// simtwo_pkg
// Types and constants shared by the two-point similarity estimator.
// ----------------------------------------------------------------------------
package simtwo_pkg;

  localparam int COORD_W = 12;              // pixel coordinate
  localparam int DIFF_W  = COORD_W + 1;     // signed difference
  localparam int PROD_W  = 2 * DIFF_W;      // difference products, dot, cross
  localparam int N2_W    = 25;              // |s|^2 < 2^25
  localparam int WIDE_W  = 40;              // translation numerators
  localparam int OUT_W   = 24;              // result fields
  localparam int Q_W     = OUT_W;           // quotient bits
  localparam int NUM_W   = 50;              // divider dividend
  localparam int DEN_W   = N2_W + 1;        // divider divisor (2*|s|^2)
  localparam int DIV_LAT = Q_W + 2;         // divider latency
  localparam int ROT_SH  = 17;              // 2 * 2^16
  localparam int TRN_SH  = 9;               // 2 * 2^8
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_DEST_FIRST_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_FIRST_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_SECOND_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_SECOND_Y = 3'd3;

  typedef struct packed {
    logic [COORD_W-1:0] src_first_x;
    logic [COORD_W-1:0] src_first_y;
    logic [COORD_W-1:0] src_second_x;
    logic [COORD_W-1:0] src_second_y;
  } in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] scaled_cos;
    logic signed [OUT_W-1:0] scaled_sin;
    logic signed [OUT_W-1:0] shift_x;
    logic signed [OUT_W-1:0] shift_y;
    logic                    degenerate;
  } out_t;

  typedef struct packed {
    logic             neg;
    logic [NUM_W-1:0] num;
  } div_in_t;

  typedef struct packed {
    logic             valid;
    logic             deg;
    logic [DEN_W-1:0] den;
    div_in_t          cos_n;
    div_in_t          sin_n;
    div_in_t          tx_n;
    div_in_t          ty_n;
  } front_t;

endpackage

// ----- src/similarity_from_two_points.sv -----
// ----------------------------------------------------------------------------
// similarity_from_two_points
// Two-point similarity transform: maps two measured points onto two target
// points, giving scaled rotation terms and translation.
// ----------------------------------------------------------------------------
// Usage:
//   Target points are written through the cfg_ channel (index 0..3 =
//   first x, first y, second x, second y); cfg_ready is always high and
//   unknown indexes are dropped. Write them only while no item is in flight.
//   An item is taken on any clock with start high; busy is always low, so
//   one item per cycle is sustained.
//   Each item gives exactly one result on out_data, marked by a one-cycle
//   out_valid pulse, after the multiply/add front end and then the
//   bit-per-stage division.
//   The receiver cannot stall; results are never held back.
//   Coincident source points give degenerate = 1 and zero fields.
//   Reset clears the target registers to zero and empties the pipeline.
// ----------------------------------------------------------------------------
module similarity_from_two_points (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  simtwo_pkg::in_t                   in_data,
  output logic                              out_valid,
  output simtwo_pkg::out_t                  out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [simtwo_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [simtwo_pkg::COORD_W-1:0]    cfg_data
);
  import simtwo_pkg::*;

  logic [COORD_W-1:0] d0x_r, d0y_r, d1x_r, d1y_r;
  logic in_fire;
  front_t front;
  logic deg_r [0:DIV_LAT-1];
  logic v_cos, v_sin, v_tx, v_ty;
  logic signed [OUT_W-1:0] q_cos, q_sin, q_tx, q_ty;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign in_fire   = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d0x_r <= '0;
      d0y_r <= '0;
      d1x_r <= '0;
      d1y_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DEST_FIRST_X:  d0x_r <= cfg_data;
        REG_DEST_FIRST_Y:  d0y_r <= cfg_data;
        REG_DEST_SECOND_X: d1x_r <= cfg_data;
        REG_DEST_SECOND_Y: d1y_r <= cfg_data;
        default: ;
      endcase
    end
  end

  simtwo_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_item (in_data),
    .d0x     (d0x_r),
    .d0y     (d0y_r),
    .d1x     (d1x_r),
    .d1y     (d1y_r),
    .front_o (front)
  );

  // degenerate flag rides alongside the dividers
  always_ff @(posedge clk) begin
    deg_r[0] <= front.deg;
    for (int k = 1; k < DIV_LAT; k++) deg_r[k] <= deg_r[k-1];
  end

  simtwo_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .Q_W(Q_W)) u_div_cos (
    .clk(clk), .rst_n(rst_n), .in_valid(front.valid), .in_neg(front.cos_n.neg),
    .in_num(front.cos_n.num), .in_den(front.den), .out_valid(v_cos), .out_quot(q_cos)
  );
  simtwo_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .Q_W(Q_W)) u_div_sin (
    .clk(clk), .rst_n(rst_n), .in_valid(front.valid), .in_neg(front.sin_n.neg),
    .in_num(front.sin_n.num), .in_den(front.den), .out_valid(v_sin), .out_quot(q_sin)
  );
  simtwo_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .Q_W(Q_W)) u_div_tx (
    .clk(clk), .rst_n(rst_n), .in_valid(front.valid), .in_neg(front.tx_n.neg),
    .in_num(front.tx_n.num), .in_den(front.den), .out_valid(v_tx), .out_quot(q_tx)
  );
  simtwo_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .Q_W(Q_W)) u_div_ty (
    .clk(clk), .rst_n(rst_n), .in_valid(front.valid), .in_neg(front.ty_n.neg),
    .in_num(front.ty_n.num), .in_den(front.den), .out_valid(v_ty), .out_quot(q_ty)
  );

  assign out_valid = v_cos & v_sin & v_tx & v_ty;

  always_comb begin
    out_data.scaled_cos = q_cos;
    out_data.scaled_sin = q_sin;
    out_data.shift_x    = q_tx;
    out_data.shift_y    = q_ty;
    out_data.degenerate = deg_r[DIV_LAT-1];
  end

endmodule

// ----- src/simtwo_front.sv -----
// ----------------------------------------------------------------------------
// simtwo_front
// Six-stage arithmetic front end: differences, products, dot and cross,
// translation numerators, then dividend/divisor setup for the dividers.
// ----------------------------------------------------------------------------
module simtwo_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_fire,
  input  simtwo_pkg::in_t                   in_item,
  input  logic [simtwo_pkg::COORD_W-1:0]    d0x,
  input  logic [simtwo_pkg::COORD_W-1:0]    d0y,
  input  logic [simtwo_pkg::COORD_W-1:0]    d1x,
  input  logic [simtwo_pkg::COORD_W-1:0]    d1y,
  output simtwo_pkg::front_t                front_o
);
  import simtwo_pkg::*;

  logic [5:0] v_r;

  // stage 1
  logic [COORD_W-1:0] s0x_1_r, s0y_1_r, d0x_1_r, d0y_1_r;
  logic signed [DIFF_W-1:0] sx_r, sy_r, dx_r, dy_r;
  // stage 2
  logic [COORD_W-1:0] s0x_2_r, s0y_2_r, d0x_2_r, d0y_2_r;
  logic signed [PROD_W-1:0] pxx_r, pyy_r, pxd_r, pyd_r, pdxsy_r, pdysx_r;
  // stage 3
  logic [COORD_W-1:0] s0x_3_r, s0y_3_r, d0x_3_r, d0y_3_r;
  logic [N2_W-1:0] n2_3_r;
  logic signed [PROD_W-1:0] dot_3_r, crs_3_r;
  // stage 4
  logic [N2_W-1:0] n2_4_r;
  logic signed [PROD_W-1:0] dot_4_r, crs_4_r;
  logic signed [WIDE_W-1:0] m0_r, m1_r, m2_r, m3_r, m4_r, m5_r;
  // stage 5
  logic [N2_W-1:0] n2_5_r;
  logic signed [PROD_W-1:0] dot_5_r, crs_5_r;
  logic signed [WIDE_W-1:0] numx_r, numy_r;
  // stage 6
  front_t out_r;

  logic signed [PROD_W-1:0] pxx_nxt, pyy_nxt;
  logic [N2_W-1:0] n2_nxt;
  logic deg_nxt;
  logic [N2_W-1:0] n2_eff;
  logic [PROD_W-2:0] mag_cos, mag_sin;
  logic [WIDE_W-2:0] mag_tx, mag_ty;
  front_t out_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[4:0], in_fire};
    end
  end

  always_ff @(posedge clk) begin
    s0x_1_r <= in_item.src_first_x;
    s0y_1_r <= in_item.src_first_y;
    d0x_1_r <= d0x;
    d0y_1_r <= d0y;
    sx_r <= $signed({1'b0, in_item.src_second_x}) - $signed({1'b0, in_item.src_first_x});
    sy_r <= $signed({1'b0, in_item.src_second_y}) - $signed({1'b0, in_item.src_first_y});
    dx_r <= $signed({1'b0, d1x}) - $signed({1'b0, d0x});
    dy_r <= $signed({1'b0, d1y}) - $signed({1'b0, d0y});

    s0x_2_r <= s0x_1_r;
    s0y_2_r <= s0y_1_r;
    d0x_2_r <= d0x_1_r;
    d0y_2_r <= d0y_1_r;
    pxx_r   <= pxx_nxt;
    pyy_r   <= pyy_nxt;
    pxd_r   <= PROD_W'(sx_r) * PROD_W'(dx_r);
    pyd_r   <= PROD_W'(sy_r) * PROD_W'(dy_r);
    pdxsy_r <= PROD_W'(dx_r) * PROD_W'(sy_r);
    pdysx_r <= PROD_W'(dy_r) * PROD_W'(sx_r);

    s0x_3_r <= s0x_2_r;
    s0y_3_r <= s0y_2_r;
    d0x_3_r <= d0x_2_r;
    d0y_3_r <= d0y_2_r;
    n2_3_r  <= n2_nxt;
    dot_3_r <= pxd_r + pyd_r;
    crs_3_r <= pdxsy_r - pdysx_r;

    n2_4_r  <= n2_3_r;
    dot_4_r <= dot_3_r;
    crs_4_r <= crs_3_r;
    m0_r <= WIDE_W'($signed({1'b0, n2_3_r})) * WIDE_W'($signed({1'b0, d0x_3_r}));
    m1_r <= WIDE_W'(dot_3_r) * WIDE_W'($signed({1'b0, s0x_3_r}));
    m2_r <= WIDE_W'(crs_3_r) * WIDE_W'($signed({1'b0, s0y_3_r}));
    m3_r <= WIDE_W'($signed({1'b0, n2_3_r})) * WIDE_W'($signed({1'b0, d0y_3_r}));
    m4_r <= WIDE_W'(dot_3_r) * WIDE_W'($signed({1'b0, s0y_3_r}));
    m5_r <= WIDE_W'(crs_3_r) * WIDE_W'($signed({1'b0, s0x_3_r}));

    n2_5_r  <= n2_4_r;
    dot_5_r <= dot_4_r;
    crs_5_r <= crs_4_r;
    numx_r  <= m0_r - m1_r - m2_r;
    numy_r  <= m3_r - m4_r + m5_r;

    out_r <= out_nxt;
  end

  assign pxx_nxt = PROD_W'(sx_r) * PROD_W'(sx_r);
  assign pyy_nxt = PROD_W'(sy_r) * PROD_W'(sy_r);
  assign n2_nxt  = N2_W'(pxx_r + pyy_r);

  // coincident points: numerators are already zero, divisor forced to 2
  assign deg_nxt = (n2_5_r == '0);
  assign n2_eff  = deg_nxt ? N2_W'(1) : n2_5_r;

  assign mag_cos = dot_5_r[PROD_W-1] ? (PROD_W-1)'(-dot_5_r) : dot_5_r[PROD_W-2:0];
  assign mag_sin = crs_5_r[PROD_W-1] ? (PROD_W-1)'(-crs_5_r) : crs_5_r[PROD_W-2:0];
  assign mag_tx  = numx_r[WIDE_W-1] ? (WIDE_W-1)'(-numx_r) : numx_r[WIDE_W-2:0];
  assign mag_ty  = numy_r[WIDE_W-1] ? (WIDE_W-1)'(-numy_r) : numy_r[WIDE_W-2:0];

  always_comb begin
    out_nxt.valid     = v_r[4];
    out_nxt.deg       = deg_nxt;
    out_nxt.den       = {n2_eff, 1'b0};
    out_nxt.cos_n.neg = dot_5_r[PROD_W-1];
    out_nxt.cos_n.num = (NUM_W'(mag_cos) << ROT_SH) + NUM_W'(n2_eff);
    out_nxt.sin_n.neg = crs_5_r[PROD_W-1];
    out_nxt.sin_n.num = (NUM_W'(mag_sin) << ROT_SH) + NUM_W'(n2_eff);
    out_nxt.tx_n.neg  = numx_r[WIDE_W-1];
    out_nxt.tx_n.num  = (NUM_W'(mag_tx) << TRN_SH) + NUM_W'(n2_eff);
    out_nxt.ty_n.neg  = numy_r[WIDE_W-1];
    out_nxt.ty_n.num  = (NUM_W'(mag_ty) << TRN_SH) + NUM_W'(n2_eff);
  end

  always_comb begin
    front_o       = out_r;
    front_o.valid = v_r[5];
  end

endmodule

// ----- src/simtwo_div.sv -----
// ----------------------------------------------------------------------------
// simtwo_div
// Pipelined restoring divider, one quotient bit per stage, with sign
// restore and saturation to a signed result.
// ----------------------------------------------------------------------------
module simtwo_div #(
  parameter int NUM_W = simtwo_pkg::NUM_W,
  parameter int DEN_W = simtwo_pkg::DEN_W,
  parameter int Q_W   = simtwo_pkg::Q_W
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_neg,
  input  logic [NUM_W-1:0]        in_num,
  input  logic [DEN_W-1:0]        in_den,
  output logic                    out_valid,
  output logic signed [Q_W-1:0]   out_quot
);
  localparam logic [Q_W-1:0] POS_MAX = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic [Q_W-1:0] NEG_MAG = {1'b1, {(Q_W-1){1'b0}}};

  logic             v_r   [0:Q_W];
  logic             neg_r [0:Q_W];
  logic             ovf_r [0:Q_W];
  logic [DEN_W-1:0] rem_r [0:Q_W];
  logic [DEN_W-1:0] den_r [0:Q_W];
  logic [Q_W-1:0]   lo_r  [0:Q_W];
  logic [Q_W-1:0]   q_r   [0:Q_W];

  logic [DEN_W:0]   trial [0:Q_W-1];
  logic             fits  [0:Q_W-1];

  logic             out_v_r;
  logic [Q_W-1:0]   out_q_r;
  logic [Q_W-1:0]   q_nxt;

  always_comb begin
    for (int k = 0; k < Q_W; k++) begin
      trial[k] = {rem_r[k], lo_r[k][Q_W-1]};
      fits[k]  = (trial[k] >= {1'b0, den_r[k]});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= Q_W; k++) v_r[k] <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      v_r[0] <= in_valid;
      for (int k = 0; k < Q_W; k++) v_r[k+1] <= v_r[k];
      out_v_r <= v_r[Q_W];
    end
  end

  always_ff @(posedge clk) begin
    // high part of the dividend must be below the divisor, else the
    // quotient needs more than Q_W bits
    neg_r[0] <= in_neg;
    ovf_r[0] <= (in_num[NUM_W-1:Q_W] >= (NUM_W-Q_W)'(in_den));
    rem_r[0] <= DEN_W'(in_num[NUM_W-1:Q_W]);
    den_r[0] <= in_den;
    lo_r[0]  <= in_num[Q_W-1:0];
    q_r[0]   <= '0;
    for (int k = 0; k < Q_W; k++) begin
      neg_r[k+1] <= neg_r[k];
      ovf_r[k+1] <= ovf_r[k];
      den_r[k+1] <= den_r[k];
      lo_r[k+1]  <= {lo_r[k][Q_W-2:0], 1'b0};
      q_r[k+1]   <= {q_r[k][Q_W-2:0], fits[k]};
      rem_r[k+1] <= fits[k] ? DEN_W'(trial[k] - {1'b0, den_r[k]}) : DEN_W'(trial[k]);
    end
    out_q_r <= q_nxt;
  end

  always_comb begin
    if (neg_r[Q_W]) begin
      if (ovf_r[Q_W] || q_r[Q_W] > NEG_MAG) q_nxt = NEG_MAG;
      else                                  q_nxt = Q_W'(-q_r[Q_W]);
    end else begin
      if (ovf_r[Q_W] || q_r[Q_W] > POS_MAX) q_nxt = POS_MAX;
      else                                  q_nxt = q_r[Q_W];
    end
  end

  assign out_valid = out_v_r;
  assign out_quot  = $signed(out_q_r);

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the two-point similarity estimator. Source point
// pairs go in as bursts with random gaps. Each result is checked, field by
// field, against an in-bench integer predictor. The target points are
// reprogrammed between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;
  import simtwo_pkg::*;

  localparam int DRAIN_CYC = 40;  // pipeline is 32 deep

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  in_t                  in_data = '0;
  logic                 out_valid;
  out_t                 out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COORD_W-1:0]   cfg_data = '0;

  logic [COORD_W-1:0] tgt_fx, tgt_fy, tgt_sx, tgt_sy;
  out_t transform_q[$];
  int   err_cnt = 0;
  int   burst_left = 0;

  similarity_from_two_points i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #(12 * 400000);
    $display("TEST FAILED");
    $finish;
  end

  // nearest, ties away from zero; den > 0
  function automatic longint round_div(longint num, longint den);
    longint mag, q;
    mag = (num < 0) ? -num : num;
    q = (mag * 2 + den) / (2 * den);
    return (num < 0) ? -q : q;
  endfunction

  function automatic logic signed [OUT_W-1:0] sat24(longint v);
    if (v > 64'sd8388607) v = 64'sd8388607;
    if (v < -64'sd8388608) v = -64'sd8388608;
    return v[OUT_W-1:0];
  endfunction

  function automatic out_t predict_transform(in_t it);
    longint s0x, s0y, sx, sy, d0x, d0y, dx, dy, n2, dot, crs, numx, numy;
    out_t r;
    s0x = it.src_first_x;
    s0y = it.src_first_y;
    sx  = longint'(it.src_second_x) - s0x;
    sy  = longint'(it.src_second_y) - s0y;
    d0x = tgt_fx;
    d0y = tgt_fy;
    dx  = longint'(tgt_sx) - d0x;
    dy  = longint'(tgt_sy) - d0y;
    n2  = sx * sx + sy * sy;
    r = '0;
    if (n2 == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    dot  = sx * dx + sy * dy;
    crs  = dx * sy - dy * sx;
    numx = d0x * n2 - (dot * s0x + crs * s0y);
    numy = d0y * n2 - (dot * s0y - crs * s0x);
    r.scaled_cos = sat24(round_div(dot * 65536, n2));
    r.scaled_sin = sat24(round_div(crs * 65536, n2));
    r.shift_x    = sat24(round_div(numx * 256, n2));
    r.shift_y    = sat24(round_div(numy * 256, n2));
    return r;
  endfunction

  task automatic report(string what, longint got, longint exp);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, exp, $realtime);
    err_cnt++;
  endtask

  // Tracks transfers on both channels and checks results.
  always @(posedge clk) begin
    out_t e;
    if (!rst_n) begin
      tgt_fx <= '0; tgt_fy <= '0; tgt_sx <= '0; tgt_sy <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_DEST_FIRST_X:  tgt_fx <= cfg_data;
          REG_DEST_FIRST_Y:  tgt_fy <= cfg_data;
          REG_DEST_SECOND_X: tgt_sx <= cfg_data;
          REG_DEST_SECOND_Y: tgt_sy <= cfg_data;
          default: ;
        endcase
      end
      if (start && !busy) transform_q.push_back(predict_transform(in_data));
      if (out_valid) begin
        if (transform_q.size() == 0) begin
          report("unexpected result", 0, 0);
        end else begin
          e = transform_q.pop_front();
          if (out_data.scaled_cos !== e.scaled_cos)
            report("scaled_cos", out_data.scaled_cos, e.scaled_cos);
          if (out_data.scaled_sin !== e.scaled_sin)
            report("scaled_sin", out_data.scaled_sin, e.scaled_sin);
          if (out_data.shift_x !== e.shift_x)
            report("shift_x", out_data.shift_x, e.shift_x);
          if (out_data.shift_y !== e.shift_y)
            report("shift_y", out_data.shift_y, e.shift_y);
          if (out_data.degenerate !== e.degenerate)
            report("degenerate", out_data.degenerate, e.degenerate);
        end
      end
    end
  end

  task automatic send_item(in_t it);
    start   <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
    end else begin
      burst_left--;
    end
  endtask

  // a burst may still hold start high; drop it before draining
  task automatic wait_idle();
    start <= 1'b0;
    while (transform_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  // Writes all four targets in one back-to-back run of transfers.
  task automatic set_targets(int fx, int fy, int sx, int sy, bit junk);
    int vals[4];
    vals = '{fx, fy, sx, sy};
    wait_idle();
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data  <= vals[i][COORD_W-1:0];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    // indexes with no register behind them must be dropped
    if (junk) begin
      for (int i = 4; i < 8; i++) begin
        cfg_index <= CFG_IDX_W'(i);
        cfg_data  <= COORD_W'($urandom);
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
      end
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic in_t mk(int ax, int ay, int bx, int by);
    in_t it;
    it.src_first_x  = ax[COORD_W-1:0];
    it.src_first_y  = ay[COORD_W-1:0];
    it.src_second_x = bx[COORD_W-1:0];
    it.src_second_y = by[COORD_W-1:0];
    return it;
  endfunction

  function automatic in_t rand_item();
    int ax, ay;
    ax = $urandom_range(0, 4095);
    ay = $urandom_range(0, 4095);
    case ($urandom_range(0, 9))
      0: return mk(ax, ay, ax, ay);  // coincident
      1, 2: return mk(ax, ay, (ax + $urandom_range(0, 6)) % 4096,
                      (ay + $urandom_range(0, 6)) % 4096);  // tiny span, saturation
      default: return mk(ax, ay, $urandom_range(0, 4095), $urandom_range(0, 4095));
    endcase
  endfunction

  task automatic test_directed();
    set_targets(4095, 4095, 0, 0, 1'b1);
    send_item(mk(0, 0, 0, 0));
    send_item(mk(4095, 4095, 4095, 4095));
    send_item(mk(0, 0, 4095, 4095));
    send_item(mk(4095, 4095, 0, 0));
    send_item(mk(4095, 0, 0, 4095));
    send_item(mk(0, 4095, 4095, 0));
    send_item(mk(0, 0, 1, 0));
    send_item(mk(4095, 4095, 4094, 4095));
    send_item(mk(2048, 2048, 2048, 2049));
    set_targets(0, 0, 4095, 0, 1'b0);
    send_item(mk(0, 0, 4095, 0));       // identity-like
    send_item(mk(0, 0, 0, 4095));       // positive quarter turn
    send_item(mk(0, 4095, 0, 0));       // negative quarter turn
    send_item(mk(100, 100, 101, 101));
    send_item(mk(4095, 0, 0, 0));
    send_item(mk(1, 2, 3, 4));
    set_targets(0, 0, 0, 0, 1'b0);
    send_item(mk(10, 20, 30, 40));
    send_item(mk(0, 0, 4095, 4095));
  endtask

  task automatic test_phase(int fx, int fy, int sx, int sy, int n);
    set_targets(fx, fy, sx, sy, 1'b1);
    repeat (n) send_item(rand_item());
  endtask

  task automatic test_random();
    test_phase(1000, 1200, 3000, 1300, 350);
    test_phase(0, 0, 4095, 4095, 300);
    test_phase(4095, 0, 0, 4095, 300);
    test_phase(2000, 2000, 2000, 2000, 200);
    repeat (3)
      test_phase($urandom_range(0, 4095), $urandom_range(0, 4095),
                 $urandom_range(0, 4095), $urandom_range(0, 4095), 200);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random();
    start <= 1'b0;
    wait_idle();
    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
